>>> hw/rtl/indexed_ordered_list_store_top_defines.svh
// Assertion helpers shared by the RTL of the ordered list store.
// All checks sample on clk and are off while rst_n is low.
`ifndef INDEXED_ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_ORDERED_LIST_STORE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ILST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ILST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ilst_pkg.sv
`default_nettype none
package ilst_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_INSERT = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } ilst_cell_op_t;

  typedef struct packed {
    ilst_cell_op_t     op;
    logic [DATA_W-1:0] data;
  } ilst_cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ilst_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/indexed_ordered_list_store_top.sv
// Ordered list store: a bounded list of signed 32-bit entries, front at index 0.
// Input channel (in_valid / in_stall): one request = command, value, position.
// Output channel (out_valid / out_stall): one result per request with the read
// value, status, length and wrapping sum after the request.
// The entries sit in a chain of cells; push and pop shift every cell at once
// and insert shifts the cells past its index. For those requests, clear and
// all refused or missed ones the result is in the output register the cycle
// after acceptance. A read that hits registers its position and goes through
// a registered OR tree over the cells; the input is stalled meanwhile.
// Throughput: one request per cycle for push/pop/insert/clear while the
// receiver takes results; a hit read holds the input until its result is
// registered, and only then can the next request be taken.
// One request is in flight at a time; a new one is taken in the same cycle
// the pending result is taken. If the receiver stalls, the result holds in
// the output register and the input stalls until it goes.
// Reset (rst_n low, synchronous) empties the list and zeroes the sum; entry
// storage is not cleared and needs no clearing pass.
`default_nettype none
module indexed_ordered_list_store_top
  import ilst_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_command,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [15:0] in_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_read_value,
  output logic             [1:0]  out_status,
  output logic             [6:0]  out_length_now,
  output logic signed      [31:0] out_total_now
);

`include "indexed_ordered_list_store_top_defines.svh"

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int LVLS  = $clog2(LIST_DEPTH);
  localparam int RC_W  = $clog2(LVLS + 1);
  localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);
  localparam logic [RC_W-1:0]  RD_LAT   = RC_W'(LVLS);

  ilst_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] total_r, total_nxt;
  logic [RC_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [IDX_W-1:0]  rd_idx_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [1:0]        out_st_r;
  logic [6:0]        out_len_r;
  logic [DATA_W-1:0] out_tot_r;

  logic              acc;
  logic              rd_done;
  logic              read_hit;
  logic [1:0]        res_st;
  logic [DATA_W-1:0] res_rd;
  ilst_cell_ctl_t    ctl;
  logic [IDX_W-1:0]  ctl_idx;

  logic [DATA_W-1:0] cell_val [LIST_DEPTH];
  logic [DATA_W-1:0] cell_rd  [LIST_DEPTH];
  logic [DATA_W-1:0] tree_root;

  logic [CMP_W-1:0]  pos_mag;
  logic [CMP_W-1:0]  cnt_ext;
  logic              pos_neg;
  logic [CNT_W+6:0]  len_ext;

  assign pos_neg = in_position[15];
  assign pos_mag = CMP_W'({1'b0, in_position[14:0]});
  assign cnt_ext = CMP_W'(count_r);

  // ---------------- FSM ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc && read_hit) state_nxt = ST_READ;
      ST_READ: if (rd_cnt_r == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_done  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = out_valid_r && out_stall;
      ST_READ: rd_done  = (rd_cnt_r == '0);
      default: ;
    endcase
  end

  assign acc = in_valid && !in_stall;

  // ---------------- command decode ----------------
  always_comb begin
    res_st    = STAT_OK;
    res_rd    = '0;
    read_hit  = 1'b0;
    count_nxt = count_r;
    total_nxt = total_r;
    ctl.op    = CELL_HOLD;
    ctl.data  = in_value;
    ctl_idx   = '0;
    case (in_command)
      CMD_PUSH: begin
        if (count_r == FULL_CNT) begin
          res_st = STAT_FULL;
        end else begin
          ctl.op    = CELL_INSERT;
          count_nxt = count_r + 1'b1;
          total_nxt = total_r + in_value;
        end
      end
      CMD_POP: begin
        if (count_r == '0) begin
          res_st = STAT_EMPTY;
        end else begin
          ctl.op    = CELL_POP;
          res_rd    = cell_val[0];
          count_nxt = count_r - 1'b1;
          total_nxt = total_r - cell_val[0];
        end
      end
      CMD_READ: begin
        res_rd = MISS_VALUE;
        if (pos_neg) begin
          res_st = STAT_RANGE;
        end else if (count_r == '0) begin
          res_st = STAT_EMPTY;
        end else if (pos_mag >= cnt_ext) begin
          res_st = STAT_RANGE;
        end else begin
          read_hit = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_neg) begin
          res_st = STAT_RANGE;
        end else if (pos_mag != '0 && count_r == '0) begin
          res_st = STAT_EMPTY;
        end else if (pos_mag > cnt_ext) begin
          res_st = STAT_RANGE;
        end else if (count_r == FULL_CNT) begin
          res_st = STAT_FULL;
        end else begin
          ctl.op    = CELL_INSERT;
          ctl_idx   = pos_mag[IDX_W-1:0];
          count_nxt = count_r + 1'b1;
          total_nxt = total_r + in_value;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
        total_nxt = '0;
      end
      default: ;
    endcase
    if (!acc) begin
      ctl.op = CELL_HOLD;
    end
  end

  assign rd_cnt_nxt = (state_r == ST_READ) ? rd_cnt_r - 1'b1 : RD_LAT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (acc) begin
        count_r <= count_nxt;
        total_r <= total_nxt;
      end
      if ((acc && !read_hit) || rd_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a finishing read reports the held count, not the decode of the waiting request
  assign len_ext = {7'd0, rd_done ? count_r : count_nxt};

  always_ff @(posedge clk) begin
    if (acc && read_hit) begin
      rd_idx_r <= pos_mag[IDX_W-1:0];
    end
    if (acc && !read_hit) begin
      out_rd_r  <= res_rd;
      out_st_r  <= res_st;
      out_len_r <= len_ext[6:0];
      out_tot_r <= total_nxt;
    end else if (rd_done) begin
      out_rd_r  <= tree_root;
      out_st_r  <= STAT_OK;
      out_len_r <= len_ext[6:0];
      out_tot_r <= total_r;
    end
  end

  // ---------------- cell chain ----------------
  genvar i;
  generate
    for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_val;
      logic [DATA_W-1:0] right_val;
      if (i == 0) begin : g_head
        assign left_val = ctl.data;
      end else begin : g_left
        assign left_val = cell_val[i-1];
      end
      if (i == LIST_DEPTH - 1) begin : g_tail
        assign right_val = cell_val[i];
      end else begin : g_right
        assign right_val = cell_val[i+1];
      end
      ilst_cell #(
        .IDX_W    (IDX_W),
        .CELL_IDX (i)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .ctl_idx   (ctl_idx),
        .rd_idx    (rd_idx_r),
        .left_val  (left_val),
        .right_val (right_val),
        .val       (cell_val[i]),
        .rd_val    (cell_rd[i])
      );
    end
  endgenerate

  ilst_read_tree #(
    .DEPTH (LIST_DEPTH)
  ) u_read_tree (
    .clk  (clk),
    .leaf (cell_rd),
    .root (tree_root)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = $signed(out_rd_r);
  assign out_status     = out_st_r;
  assign out_length_now = out_len_r;
  assign out_total_now  = $signed(out_tot_r);

  // ---------------- checks ----------------
  `ILST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT, "entry count above depth")
  `ILST_ASSERT_NOW(a_read_blocks_in, state_r == ST_READ, in_stall, "input taken during read")
  `ILST_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r,
                    "stalled result dropped")
  `ILST_ASSERT_NEXT(a_read_state_frozen, state_r == ST_READ,
                    $stable(count_r) && $stable(total_r), "list changed during read")

endmodule
`default_nettype wire

>>> hw/rtl/ilst_cell.sv
`default_nettype none
module ilst_cell
  import ilst_pkg::*;
#(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic                 clk,
  input  wire ilst_cell_ctl_t       ctl,
  input  wire logic [IDX_W-1:0]     ctl_idx,
  input  wire logic [IDX_W-1:0]     rd_idx,
  input  wire logic [DATA_W-1:0]    left_val,
  input  wire logic [DATA_W-1:0]    right_val,
  output logic      [DATA_W-1:0]    val,
  output logic      [DATA_W-1:0]    rd_val
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [DATA_W-1:0] val_r;

  // insert: cells past the index take the left neighbor; pop: everyone moves toward the head
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (MY_IDX == ctl_idx) begin
          val_r <= ctl.data;
        end else if (MY_IDX > ctl_idx) begin
          val_r <= left_val;
        end
      end
      CELL_POP: val_r <= right_val;
      default: ;
    endcase
  end

  assign val    = val_r;
  assign rd_val = (MY_IDX == rd_idx) ? val_r : '0;

endmodule
`default_nettype wire

>>> hw/rtl/ilst_read_tree.sv
`default_nettype none
module ilst_read_tree
  import ilst_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic [DATA_W-1:0] leaf [DEPTH],
  output logic      [DATA_W-1:0] root
);

  localparam int LVLS = $clog2(DEPTH);
  localparam int P    = 1 << LVLS;

  logic [DATA_W-1:0] leaf_pad [P];
  logic [DATA_W-1:0] node_r   [1:P-1];

  // only the selected cell drives nonzero data, so an OR tree picks it out
  genvar i, n;
  generate
    for (i = 0; i < P; i++) begin : g_leaf
      if (i < DEPTH) begin : g_real
        assign leaf_pad[i] = leaf[i];
      end else begin : g_pad
        assign leaf_pad[i] = '0;
      end
    end
    for (n = 1; n < P; n++) begin : g_node
      if (n >= P / 2) begin : g_bottom
        always_ff @(posedge clk) begin
          node_r[n] <= leaf_pad[2*n-P] | leaf_pad[2*n+1-P];
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node_r[n] <= node_r[2*n] | node_r[2*n+1];
        end
      end
    end
  endgenerate

  assign root = node_r[1];

endmodule
`default_nettype wire
